>>> hdl/dshot_frame_spi_encoder_assert.svh
// assertion macros used by the dshot frame encoder checker
`ifndef DSHOT_FRAME_SPI_ENCODER_ASSERT_SVH
`define DSHOT_FRAME_SPI_ENCODER_ASSERT_SVH

// property checked outside reset
`define DFSE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define DFSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/dfse_pkg.sv
// types, constants and waveform functions of the dshot frame encoder
package dfse_pkg;

    localparam int SPEED_W      = 26;
    localparam int VALUE_W      = 16;
    localparam int FRAME_W      = 16;
    localparam int MAX_BYTES    = 18;
    localparam int STREAM_W     = MAX_BYTES * 8;
    localparam int IDX_W        = 5;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [SPEED_W-1:0] SPEED_RESET   = 26'd2400000;
    localparam logic [SPEED_W-1:0] SPEED_900K    = 26'd900000;
    localparam logic [SPEED_W-1:0] SPEED_1400K   = 26'd1400000;
    localparam logic [SPEED_W-1:0] SPEED_1500K   = 26'd1500000;
    localparam logic [SPEED_W-1:0] SPEED_1600K   = 26'd1600000;
    localparam logic [10:0]        VALUE_MAX     = 11'd2047;

    // waveform codes
    localparam logic [1:0] MODE_SYM3    = 2'd0;
    localparam logic [1:0] MODE_SYM5    = 2'd1;
    localparam logic [1:0] MODE_SYM5_PAD = 2'd2;
    localparam logic [1:0] MODE_SYM8    = 2'd3;

    // symbol patterns
    localparam logic [2:0] SYM3_ONE   = 3'b110;
    localparam logic [2:0] SYM3_ZERO  = 3'b100;
    localparam logic [4:0] SYM5_ONE   = 5'h1e;
    localparam logic [4:0] SYM5_ZERO  = 5'h10;
    localparam logic [4:0] SYM5P_ZERO = 5'h18;
    localparam logic [7:0] SYM8_ONE   = 8'hfc;
    localparam logic [7:0] SYM8_ZERO  = 8'he0;

    typedef struct packed {
        logic [VALUE_W-1:0] throttle_value;
        logic               telemetry_request;
    } in_item_t;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       last_byte;
    } out_item_t;

    // classified frame handed from front to back
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [1:0]         mode;
    } frame_cmd_t;

    // saturate, append telemetry bit and xor checksum
    function automatic logic [FRAME_W-1:0] build_frame(logic [VALUE_W-1:0] value,
                                                        logic telem);
        logic [10:0] sat;
        logic [11:0] word;
        logic [3:0]  csum;
        sat  = (value > VALUE_W'(VALUE_MAX)) ? VALUE_MAX : value[10:0];
        word = {sat, telem};
        csum = word[3:0] ^ word[7:4] ^ word[11:8];
        return {word, csum};
    endfunction

    // pick the waveform from the spi clock rate
    function automatic logic [1:0] speed_mode(logic [SPEED_W-1:0] speed);
        logic [1:0] m;
        if (speed == SPEED_900K)
            m = MODE_SYM3;
        else if (speed == SPEED_1400K)
            m = MODE_SYM5;
        else if (speed >= SPEED_1500K && speed <= SPEED_1600K)
            m = MODE_SYM5_PAD;
        else
            m = MODE_SYM8;
        return m;
    endfunction

    // index of the final byte of a run
    function automatic logic [IDX_W-1:0] last_index(logic [1:0] mode);
        logic [IDX_W-1:0] r;
        case (mode)
            MODE_SYM3:     r = IDX_W'(6);
            MODE_SYM5:     r = IDX_W'(10);
            MODE_SYM5_PAD: r = IDX_W'(11);
            MODE_SYM8:     r = IDX_W'(17);
            default:       r = IDX_W'(17);
        endcase
        return r;
    endfunction

    // full bit stream of a frame, first bit sent at the top
    function automatic logic [STREAM_W-1:0] wave_stream(logic [FRAME_W-1:0] frame,
                                                         logic [1:0] mode);
        logic [STREAM_W-1:0] s;
        logic                f;
        s = '0;
        for (int i = 0; i < FRAME_W; i++)
        begin
            f = frame[FRAME_W-1-i];
            case (mode)
                MODE_SYM3:
                    s[STREAM_W-1-3*i -: 3] = f ? SYM3_ONE : SYM3_ZERO;
                MODE_SYM5:
                    s[STREAM_W-1-5*i -: 5] = f ? SYM5_ONE : SYM5_ZERO;
                MODE_SYM5_PAD:
                    s[STREAM_W-9-5*i -: 5] = f ? SYM5_ONE : SYM5P_ZERO;
                default:
                    s[STREAM_W-1-8*i -: 8] = f ? SYM8_ONE : SYM8_ZERO;
            endcase
        end
        return s;
    endfunction

endpackage

>>> hdl/dfse_front.sv
// front: speed register, frame build and waveform classification
module dfse_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dfse_pkg::SPEED_W-1:0]  cfg_data,
    input  logic                          push,
    input  dfse_pkg::in_item_t            in_item,
    input  logic                          q_full,
    output logic                          q_wr,
    output dfse_pkg::frame_cmd_t          q_wdata
);
    import dfse_pkg::*;

    logic [SPEED_W-1:0] speed_reg;

    // speed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            speed_reg <= SPEED_RESET;
        else if (cfg_we)
            speed_reg <= cfg_data;
    end

    // accept and classify an item
    assign q_wr          = push && !q_full;
    assign q_wdata.frame = build_frame(in_item.throttle_value, in_item.telemetry_request);
    assign q_wdata.mode  = speed_mode(speed_reg);

endmodule

>>> hdl/dfse_queue.sv
// short queue of classified frames between front and back
module dfse_queue #(
    parameter int DEPTH = dfse_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr,
    input  dfse_pkg::frame_cmd_t  wdata,
    input  logic                  rd,
    output dfse_pkg::frame_cmd_t  rdata,
    output logic                  full,
    output logic                  empty
);
    import dfse_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    frame_cmd_t     slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_wr, do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wdata;
    end

endmodule

>>> hdl/dfse_back.sv
// back: byte sequencer and output register
module dfse_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  dfse_pkg::frame_cmd_t  q_rdata,
    output logic                  q_rd,
    input  logic                  pop,
    output logic                  empty,
    output dfse_pkg::out_item_t   out_item
);
    import dfse_pkg::*;

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                valid_reg, valid_next;
    out_item_t           data_reg;
    logic [STREAM_W-1:0] stream;
    logic                advance, take, at_last;
    logic [7:0]          cur_byte;

    // current byte of the head frame
    assign stream   = wave_stream(q_rdata.frame, q_rdata.mode);
    assign cur_byte = stream[STREAM_W-1-8*idx_reg -: 8];
    assign at_last  = (idx_reg == last_index(q_rdata.mode));

    // output slot is free or being taken
    assign advance = !valid_reg || pop;
    assign take    = advance && !q_empty;
    assign q_rd    = take && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = take || (valid_reg && !pop);
        if (take)
            idx_next = at_last ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg.spi_byte  <= cur_byte;
            data_reg.last_byte <= at_last;
        end
    end

    assign empty    = !valid_reg;
    assign out_item = data_reg;

endmodule

>>> hdl/dshot_frame_spi_encoder.sv
// DShot frame encoder: turns throttle items into runs of SPI bytes.
// Each item gives a 16-bit value (saturated at 2047 to 11 bits) and a telemetry bit; a
// 16-bit frame with xor checksum is built and sent as 7, 11, 12 or 18 bytes,
// the waveform picked by the spi_speed register at the time the item is
// accepted. Bytes leave at one per clock from the back sequencer while pop
// takes them, and runs of successive frames follow each other with no gap
// when the next frame is queued. The input side takes an item whenever the
// frame queue between front and back has room, independent of output stalls;
// with the back idle, the first byte of an item passes through the queue slot
// and then the output register before it is offered.
module dshot_frame_spi_encoder #(
    parameter int QUEUE_DEPTH = dfse_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dfse_pkg::SPEED_W-1:0]  cfg_data,
    input  logic                          push,
    output logic                          full,
    input  dfse_pkg::in_item_t            in_item,
    input  logic                          pop,
    output logic                          empty,
    output dfse_pkg::out_item_t           out_item
);
    import dfse_pkg::*;

    frame_cmd_t q_wdata, q_rdata;
    logic       q_wr, q_rd, q_full, q_empty;

    // front end
    dfse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .push     (push),
        .in_item  (in_item),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_wdata  (q_wdata)
    );

    // frame queue
    dfse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .rd    (q_rd),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    // back end
    dfse_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_rdata  (q_rdata),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .out_item (out_item)
    );

    assign full = q_full;

endmodule

>>> hdl/dfse_checker.sv
// port checker for the dshot frame encoder and its bind
`include "dshot_frame_spi_encoder_assert.svh"

module dfse_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 full,
    input  logic                 pop,
    input  logic                 empty,
    input  dfse_pkg::out_item_t  out_item
);
    import dfse_pkg::*;

    // a waiting item holds until taken
    `DFSE_ASSERT(a_out_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_item)), "output item changed while stalled")

    // the closing byte of every run is a zero byte
    `DFSE_ASSERT(a_last_zero, clk, rst_n, (!empty && out_item.last_byte) |-> (out_item.spi_byte == 8'h00), "last byte of a run is not zero")

    // reset leaves both sides idle
    `DFSE_ASSERT_ALWAYS(a_reset_idle, clk, (!rst_n) |-> (empty && !full), "block not idle in reset")

endmodule

bind dshot_frame_spi_encoder dfse_checker u_dfse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
);
